### rtl/fpt_pkg.sv
// Frame pacing timer: shared types and constants.
// Used by fpt_rate_div and frame_pacing_timer_unit; no dependencies.
`default_nettype none

package fpt_pkg;

    localparam int NOW_W    = 63;
    localparam int CFG_W    = 36;
    localparam int RATE_W   = 24;
    localparam int FRAMES_W = 64;
    localparam int WCNT_W   = 32;
    localparam int PROD_W   = 85;   // frames * 5^9 fits in 64 + 21 bits

    // 256e9 = 5^9 * 2^17: nine times-5 steps, then a shift by 17
    localparam int MUL_STEPS = 9;
    localparam int QUOT_BITS = 24;

    localparam logic [CFG_W-1:0]  DEFAULT_PERIOD_NS = 36'd16666667;
    localparam logic [CFG_W-1:0]  DEFAULT_WINDOW_NS = 36'd250000000;
    localparam logic [CFG_W-1:0]  DELTA_MAX         = 36'hF_FFFF_FFFF;
    localparam logic [RATE_W-1:0] RATE_MAX          = 24'hFF_FFFF;
    localparam logic [WCNT_W-1:0] WCNT_MAX          = 32'hFFFF_FFFF;

    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    localparam logic FUNC_SYNC    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic                start;
        logic [FRAMES_W-1:0] num;
        logic [NOW_W-1:0]    den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

### rtl/frame_pacing_timer_unit.sv
// Frame pacing timer with windowed and lifetime frame-rate meters.
// Top level: sequencer, timing state, config registers, output register.
// Depends on fpt_pkg and fpt_rate_div.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+----------------------------------------
//  in      | i_in_valid / o_in_stall     | i_func, i_now_ns
//  out     | o_out_valid / i_out_stall   | o_frame_due, o_delta_ns, o_recent_rate,
//          |                             | o_mean_rate, o_frames_total
//  cfg     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Restart, first sync and non-firing sync pass through S_EVAL and S_OUT only.
// A firing sync runs up to two rate divisions on one shared divider, each of
// 9 multiply steps, 1 saturation check, 24 quotient bits (skipped if it
// saturates) and a hand back. Input is stalled until the result is loaded
// into the output register; a stalled output holds the block in its final state.
// Synchronous active-low reset; config is always ready.
`default_nettype none

module frame_pacing_timer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input beats
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_func,
    input  wire logic [fpt_pkg::NOW_W-1:0]     i_now_ns,
    // result beats
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_frame_due,
    output logic [fpt_pkg::CFG_W-1:0]          o_delta_ns,
    output logic [fpt_pkg::RATE_W-1:0]         o_recent_rate,
    output logic [fpt_pkg::RATE_W-1:0]         o_mean_rate,
    output logic [fpt_pkg::FRAMES_W-1:0]       o_frames_total,
    // config writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [fpt_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_WIN   = 3'd2;
    localparam logic [2:0] S_WWAIT = 3'd3;
    localparam logic [2:0] S_MEAN  = 3'd4;
    localparam logic [2:0] S_MWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                     r_state;
    logic                           r_func;
    logic [fpt_pkg::NOW_W-1:0]      r_now;
    logic [fpt_pkg::CFG_W-1:0]      r_target;
    logic [fpt_pkg::CFG_W-1:0]      r_window;

    logic                           r_awaiting;
    logic [fpt_pkg::NOW_W-1:0]      r_last;
    logic [fpt_pkg::NOW_W-1:0]      r_start;
    logic [fpt_pkg::NOW_W-1:0]      r_wstart;
    logic [fpt_pkg::FRAMES_W-1:0]   r_frame_count;
    logic [fpt_pkg::WCNT_W-1:0]     r_wcount;
    logic [fpt_pkg::CFG_W-1:0]      r_delta;
    logic [fpt_pkg::RATE_W-1:0]     r_recent;
    logic [fpt_pkg::RATE_W-1:0]     r_mean;
    logic                           r_due;

    logic                           r_out_valid;
    logic                           r_out_due;
    logic [fpt_pkg::CFG_W-1:0]      r_out_delta;
    logic [fpt_pkg::RATE_W-1:0]     r_out_recent;
    logic [fpt_pkg::RATE_W-1:0]     r_out_mean;
    logic [fpt_pkg::FRAMES_W-1:0]   r_out_frames;

    logic                           in_accept;
    logic                           out_load;
    logic [fpt_pkg::CFG_W-1:0]      period;
    logic [fpt_pkg::CFG_W+1:0]      period_x3;
    logic [fpt_pkg::NOW_W:0]        e_diff;
    logic                           fire;
    logic [fpt_pkg::CFG_W-1:0]      n_delta;
    logic [fpt_pkg::NOW_W-1:0]      span_base;
    logic [fpt_pkg::NOW_W:0]        s_diff;
    logic                           span_pos;
    logic                           win_hit;
    logic [fpt_pkg::WCNT_W-1:0]     n_wcount;
    fpt_pkg::t_div_req              div_req;
    fpt_pkg::t_div_rsp              div_rsp;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_cfg_ready = 1'b1;

    // sync evaluation: elapsed since last frame, fire test, delta clamp
    always_comb begin
        period    = (r_target != '0) ? r_target : fpt_pkg::DEFAULT_PERIOD_NS;
        period_x3 = {2'b00, period} + {1'b0, period, 1'b0};
        e_diff    = {1'b0, r_now} - {1'b0, r_last};
        fire      = !e_diff[fpt_pkg::NOW_W]
                 && (e_diff[fpt_pkg::NOW_W-1:0] >= {27'd0, period});
        if (e_diff[fpt_pkg::NOW_W-1:0] > {25'd0, period_x3}) begin
            n_delta = period;
        end else if (e_diff[fpt_pkg::NOW_W-1:fpt_pkg::CFG_W] != '0) begin
            n_delta = fpt_pkg::DELTA_MAX;
        end else begin
            n_delta = e_diff[fpt_pkg::CFG_W-1:0];
        end
        n_wcount = (r_wcount != fpt_pkg::WCNT_MAX) ? r_wcount + 32'd1 : r_wcount;
    end

    // one span subtractor: window span in S_WIN, lifetime span in S_MEAN
    always_comb begin
        span_base = (r_state == S_WIN) ? r_wstart : r_start;
        s_diff    = {1'b0, r_now} - {1'b0, span_base};
        span_pos  = !s_diff[fpt_pkg::NOW_W] && (s_diff[fpt_pkg::NOW_W-1:0] != '0);
        win_hit   = span_pos && (s_diff[fpt_pkg::NOW_W-1:0] >= {27'd0, r_window});

        div_req.den = s_diff[fpt_pkg::NOW_W-1:0];
        if (r_state == S_WIN) begin
            div_req.start = win_hit;
            div_req.num   = {32'd0, r_wcount};
        end else begin
            div_req.start = (r_state == S_MEAN) && span_pos;
            div_req.num   = r_frame_count;
        end
    end

    fpt_rate_div u_rate_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= fpt_pkg::DEFAULT_PERIOD_NS;
            r_window <= fpt_pkg::DEFAULT_WINDOW_NS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fpt_pkg::CFG_TARGET: r_target <= i_cfg_data;
                fpt_pkg::CFG_WINDOW: r_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_awaiting    <= 1'b1;
            r_last        <= '0;
            r_start       <= '0;
            r_wstart      <= '0;
            r_frame_count <= '0;
            r_wcount      <= '0;
            r_delta       <= '0;
            r_recent      <= '0;
            r_mean        <= '0;
            r_due         <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_func  <= i_func;
                        r_now   <= i_now_ns;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_func == fpt_pkg::FUNC_RESTART) begin
                        r_start       <= r_now;
                        r_wstart      <= r_now;
                        r_last        <= '0;
                        r_awaiting    <= 1'b1;
                        r_frame_count <= '0;
                        r_wcount      <= '0;
                        r_delta       <= '0;
                        r_recent      <= '0;
                        r_mean        <= '0;
                        r_due         <= 1'b0;
                        r_state       <= S_OUT;
                    end else if (r_awaiting) begin
                        r_awaiting    <= 1'b0;
                        r_last        <= r_now;
                        r_delta       <= '0;
                        r_frame_count <= 64'd1;
                        r_wcount      <= 32'd1;
                        r_due         <= 1'b1;
                        r_state       <= S_OUT;
                    end else if (fire) begin
                        r_last        <= r_now;
                        r_delta       <= n_delta;
                        r_frame_count <= r_frame_count + 64'd1;
                        r_wcount      <= n_wcount;
                        r_due         <= 1'b1;
                        r_state       <= S_WIN;
                    end else begin
                        r_due   <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_WIN: begin
                    r_state <= win_hit ? S_WWAIT : S_MEAN;
                end
                S_WWAIT: begin
                    if (div_rsp.done) begin
                        r_recent <= div_rsp.quot;
                        r_wcount <= '0;
                        r_wstart <= r_now;
                        r_state  <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    r_state <= span_pos ? S_MWAIT : S_OUT;
                end
                S_MWAIT: begin
                    if (div_rsp.done) begin
                        r_mean  <= div_rsp.quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: holds a finished beat while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_due    <= r_due;
            r_out_delta  <= r_delta;
            r_out_recent <= r_recent;
            r_out_mean   <= r_mean;
            r_out_frames <= r_frame_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_due    = r_out_due;
    assign o_delta_ns     = r_out_delta;
    assign o_recent_rate  = r_out_recent;
    assign o_mean_rate    = r_out_mean;
    assign o_frames_total = r_out_frames;

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EVAL))
        else $error("accepted beat did not start evaluation");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_WWAIT || r_state == S_MWAIT))
        else $error("divider finished outside a wait state");

    a_restart_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_func == fpt_pkg::FUNC_RESTART)
        |=> (r_state == S_OUT && r_awaiting && r_frame_count == '0 && !r_due))
        else $error("restart did not clear timing state");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("result load lost");

endmodule

`default_nettype wire

### rtl/fpt_rate_div.sv
// Iterative rate divider: floor(num * 256e9 / den), saturated to 24 bits.
// One shared 85-bit adder does times-5 steps, the saturation compare and
// the restoring division steps. Depends on fpt_pkg.
`default_nettype none

module fpt_rate_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fpt_pkg::t_div_req i_req,
    output fpt_pkg::t_div_rsp      o_rsp
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_SAT  = 2'd2;
    localparam logic [1:0] D_DIV  = 2'd3;

    logic [1:0]                   r_state;
    logic [4:0]                   r_cnt;
    logic [fpt_pkg::PROD_W-1:0]   r_m;
    logic [fpt_pkg::NOW_W-1:0]    r_d;
    logic [fpt_pkg::NOW_W-1:0]    r_rem;
    logic [fpt_pkg::QUOT_BITS-1:0] r_plow;
    logic [fpt_pkg::RATE_W-1:0]   r_q;
    logic                         r_done;

    logic [fpt_pkg::PROD_W-1:0] add_a;
    logic [fpt_pkg::PROD_W-1:0] add_b;
    logic                       add_cin;
    logic [fpt_pkg::PROD_W:0]   add_sum;
    logic                       ge;

    // shared adder; with b = ~den and cin = 1 the carry out means a >= den
    always_comb begin
        unique case (r_state)
            D_MUL: begin
                add_a   = r_m;
                add_b   = {r_m[fpt_pkg::PROD_W-3:0], 2'b00};
                add_cin = 1'b0;
            end
            D_SAT: begin
                add_a   = {7'd0, r_m[fpt_pkg::PROD_W-1:7]};
                add_b   = ~{22'd0, r_d};
                add_cin = 1'b1;
            end
            D_DIV: begin
                add_a   = {21'd0, r_rem, r_plow[fpt_pkg::QUOT_BITS-1]};
                add_b   = ~{22'd0, r_d};
                add_cin = 1'b1;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + {{fpt_pkg::PROD_W{1'b0}}, add_cin};
        ge      = add_sum[fpt_pkg::PROD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_m     <= {21'd0, i_req.num};
                        r_d     <= i_req.den;
                        r_cnt   <= '0;
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    r_m   <= add_sum[fpt_pkg::PROD_W-1:0];
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(fpt_pkg::MUL_STEPS - 1)) begin
                        r_state <= D_SAT;
                    end
                end
                D_SAT: begin
                    // product = m << 17; quotient >= 2^24 iff product[101:24] >= den
                    if (ge) begin
                        r_q     <= fpt_pkg::RATE_MAX;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_rem   <= r_m[69:7];
                        r_plow  <= {r_m[6:0], 17'd0};
                        r_cnt   <= '0;
                        r_state <= D_DIV;
                    end
                end
                D_DIV: begin
                    r_rem  <= ge ? add_sum[fpt_pkg::NOW_W-1:0]
                                 : {r_rem[fpt_pkg::NOW_W-2:0],
                                    r_plow[fpt_pkg::QUOT_BITS-1]};
                    r_q    <= {r_q[fpt_pkg::RATE_W-2:0], ge};
                    r_plow <= {r_plow[fpt_pkg::QUOT_BITS-2:0], 1'b0};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(fpt_pkg::QUOT_BITS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for frame_pacing_timer_unit: a directed table, then random sync/restart
// phases under several register settings, each result checked against an inline predictor
// or a fixed expected value. Depends on fpt_pkg and the frame_pacing_timer_unit RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                         due;
        logic [fpt_pkg::CFG_W-1:0]    delta;
        logic [fpt_pkg::RATE_W-1:0]   recent;
        logic [fpt_pkg::RATE_W-1:0]   mean;
        logic [fpt_pkg::FRAMES_W-1:0] frames;
    } t_frame_result;

    typedef enum logic [0:0] {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic                      func;
        logic [fpt_pkg::NOW_W-1:0] now;
        logic                      typed;
        t_frame_result             want;
        logic                      cfg_idx;
        logic [fpt_pkg::CFG_W-1:0] cfg_data;
    } t_stim_row;

    // ns per second times 256 (rates are in 1/256 fps)
    localparam logic [127:0]  FPS_Q8_SCALE = 128'd256000000000;
    localparam logic [fpt_pkg::NOW_W-1:0] STAMP_MAX = '1;
    localparam logic [fpt_pkg::CFG_W-1:0] CFG_MAX   = '1;
    localparam t_frame_result RES_CLEAR = '0;
    localparam t_frame_result RES_FIRST = {1'b1, 36'd0, 24'd0, 24'd0, 64'd1};
    localparam t_frame_result RES_HOLD1 = {1'b0, 36'd0, 24'd0, 24'd0, 64'd1};

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         i_func      = fpt_pkg::FUNC_SYNC;
    logic [fpt_pkg::NOW_W-1:0]    i_now_ns    = '0;
    logic                         i_out_stall = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         i_cfg_index = fpt_pkg::CFG_TARGET;
    logic [fpt_pkg::CFG_W-1:0]    i_cfg_data  = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic                         o_frame_due;
    logic [fpt_pkg::CFG_W-1:0]    o_delta_ns;
    logic [fpt_pkg::RATE_W-1:0]   o_recent_rate;
    logic [fpt_pkg::RATE_W-1:0]   o_mean_rate;
    logic [fpt_pkg::FRAMES_W-1:0] o_frames_total;
    logic                         o_cfg_ready;

    frame_pacing_timer_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_now_ns       (i_now_ns),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_due    (o_frame_due),
        .o_delta_ns     (o_delta_ns),
        .o_recent_rate  (o_recent_rate),
        .o_mean_rate    (o_mean_rate),
        .o_frames_total (o_frames_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state, reset values as after a hardware reset
    logic [fpt_pkg::CFG_W-1:0]    cfg_period     = fpt_pkg::DEFAULT_PERIOD_NS;
    logic [fpt_pkg::CFG_W-1:0]    cfg_window     = fpt_pkg::DEFAULT_WINDOW_NS;
    logic                         st_awaiting    = 1'b1;
    logic [63:0]                  st_last_stamp  = '0;
    logic [63:0]                  st_start_stamp = '0;
    logic [63:0]                  st_win_stamp   = '0;
    logic [fpt_pkg::FRAMES_W-1:0] st_frames      = '0;
    logic [fpt_pkg::WCNT_W-1:0]   st_win_frames  = '0;
    logic [fpt_pkg::CFG_W-1:0]    st_delta       = '0;
    logic [fpt_pkg::RATE_W-1:0]   st_recent      = '0;
    logic [fpt_pkg::RATE_W-1:0]   st_mean        = '0;

    t_frame_result outcome_q[$];
    int            err_cnt     = 0;
    bit            quiet_phase = 1'b0;
    int            stall_left  = 0;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet_phase || pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // floor(count * 256e9 / span), saturated
    function automatic logic [fpt_pkg::RATE_W-1:0] fps_q8(input logic [63:0] count,
                                                          input logic [63:0] span);
        logic [127:0] quot;
        quot = ({64'd0, count} * FPS_Q8_SCALE) / {64'd0, span};
        if (quot > {104'd0, fpt_pkg::RATE_MAX})
            return fpt_pkg::RATE_MAX;
        return quot[fpt_pkg::RATE_W-1:0];
    endfunction

    function automatic t_frame_result pacing_outcome(input logic func,
                                                     input logic [fpt_pkg::NOW_W-1:0] now_in);
        logic [63:0]   now;
        logic [63:0]   period;
        logic [63:0]   elapsed;
        logic [63:0]   delta;
        logic [63:0]   wspan;
        logic [63:0]   tspan;
        t_frame_result res;
        now     = {1'b0, now_in};
        res.due = 1'b0;
        if (func == fpt_pkg::FUNC_RESTART) begin
            st_start_stamp = now;
            st_win_stamp   = now;
            st_last_stamp  = '0;
            st_awaiting    = 1'b1;
            st_frames      = '0;
            st_win_frames  = '0;
            st_delta       = '0;
            st_recent      = '0;
            st_mean        = '0;
        end else if (st_awaiting) begin
            st_awaiting   = 1'b0;
            st_last_stamp = now;
            st_delta      = '0;
            st_frames     = 64'd1;
            st_win_frames = 32'd1;
            res.due       = 1'b1;
        end else if (now >= st_last_stamp) begin
            period  = (cfg_period != '0) ? {28'd0, cfg_period}
                                         : {28'd0, fpt_pkg::DEFAULT_PERIOD_NS};
            elapsed = now - st_last_stamp;
            if (elapsed >= period) begin
                delta = elapsed;
                if (delta > period * 64'd3)
                    delta = period;
                st_delta      = (delta > {28'd0, fpt_pkg::DELTA_MAX}) ? fpt_pkg::DELTA_MAX
                                                                      : delta[fpt_pkg::CFG_W-1:0];
                st_last_stamp = now;
                st_frames     = st_frames + 64'd1;
                if (st_win_frames != fpt_pkg::WCNT_MAX)
                    st_win_frames = st_win_frames + 32'd1;
                res.due = 1'b1;
                wspan = (now >= st_win_stamp) ? now - st_win_stamp : 64'd0;
                if (wspan != 64'd0 && wspan >= {28'd0, cfg_window}) begin
                    st_recent     = fps_q8({32'd0, st_win_frames}, wspan);
                    st_win_frames = '0;
                    st_win_stamp  = now;
                end
                tspan = (now >= st_start_stamp) ? now - st_start_stamp : 64'd0;
                if (tspan != 64'd0)
                    st_mean = fps_q8(st_frames, tspan);
            end
        end
        res.delta  = st_delta;
        res.recent = st_recent;
        res.mean   = st_mean;
        res.frames = st_frames;
        return res;
    endfunction

    function automatic t_stim_row beat_row(input logic func,
                                           input logic [fpt_pkg::NOW_W-1:0] now,
                                           input logic typed, input t_frame_result want);
        t_stim_row row;
        row          = '0;
        row.kind     = ROW_BEAT;
        row.func     = func;
        row.now      = now;
        row.typed    = typed;
        row.want     = want;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic idx,
                                          input logic [fpt_pkg::CFG_W-1:0] data);
        t_stim_row row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.cfg_idx  = idx;
        row.cfg_data = data;
        return row;
    endfunction

    // valid stays high after the accepting edge; the next call decides whether to drop it
    task automatic send_beat(input logic func, input logic [fpt_pkg::NOW_W-1:0] now,
                             input logic typed, input t_frame_result want);
        int            gap;
        t_frame_result pred;
        gap = gap_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_now_ns   <= now;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pred = pacing_outcome(func, now);
        outcome_q.push_back(typed ? want : pred);
    endtask

    task automatic reg_write(input logic idx, input logic [fpt_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == fpt_pkg::CFG_TARGET)
            cfg_period = data;
        else
            cfg_window = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // every beat yields a result, so an empty queue means the block is idle
    task automatic settle_idle();
        int n;
        i_in_valid <= 1'b0;
        for (n = 0; outcome_q.size() != 0 && n < 20000; n++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : out_stall_gen
        if (stall_left != 0) begin
            stall_left--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            stall_left = gap_len();
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                $error("result beat with nothing expected");
                err_cnt++;
            end else begin
                want = outcome_q.pop_front();
                if (o_frame_due !== want.due) begin
                    $error("frame_due: expected %0d, got %0d", want.due, o_frame_due);
                    err_cnt++;
                end
                if (o_delta_ns !== want.delta) begin
                    $error("delta_ns: expected %0d, got %0d", want.delta, o_delta_ns);
                    err_cnt++;
                end
                if (o_recent_rate !== want.recent) begin
                    $error("recent_rate: expected %0d, got %0d", want.recent, o_recent_rate);
                    err_cnt++;
                end
                if (o_mean_rate !== want.mean) begin
                    $error("mean_rate: expected %0d, got %0d", want.mean, o_mean_rate);
                    err_cnt++;
                end
                if (o_frames_total !== want.frames) begin
                    $error("frames_total: expected %0d, got %0d", want.frames, o_frames_total);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : drive
        t_stim_row                 plan[$];
        int                        rand_beats;
        int                        span;
        int                        k;
        logic [63:0]               r64;
        logic [63:0]               period;
        logic [63:0]               stamp64;
        logic [63:0]               step;
        logic [fpt_pkg::NOW_W-1:0] stamp;
        logic [fpt_pkg::CFG_W-1:0] per;
        logic [fpt_pkg::CFG_W-1:0] win;
        logic                      func;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values first, then the corner cases
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd1000, 1'b1, RES_FIRST));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd1010, 1'b1, RES_HOLD1));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd16667667, 1'b0, RES_CLEAR));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd500, 1'b0, RES_CLEAR));   // backwards
        // clamp + window
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd300000000, 1'b0, RES_CLEAR));
        plan.push_back(beat_row(fpt_pkg::FUNC_RESTART, 63'd5000000000, 1'b1, RES_CLEAR));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd5000000000, 1'b1, RES_FIRST));
        // exactly one period
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd5016666667, 1'b0, RES_CLEAR));
        // before start
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd4000000000, 1'b0, RES_CLEAR));
        plan.push_back(beat_row(fpt_pkg::FUNC_RESTART, STAMP_MAX, 1'b1, RES_CLEAR));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd0, 1'b1, RES_FIRST));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'h4000_0000_0000_0000, 1'b0,
                                RES_CLEAR));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, STAMP_MAX, 1'b0, RES_CLEAR));
        plan.push_back(cfg_row(fpt_pkg::CFG_TARGET, 36'd1));
        plan.push_back(cfg_row(fpt_pkg::CFG_WINDOW, 36'd1));
        plan.push_back(beat_row(fpt_pkg::FUNC_RESTART, 63'd0, 1'b1, RES_CLEAR));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd0, 1'b1, RES_FIRST));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd1, 1'b0, RES_CLEAR));   // rates saturate
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd2, 1'b0, RES_CLEAR));
        plan.push_back(cfg_row(fpt_pkg::CFG_TARGET, CFG_MAX));
        plan.push_back(cfg_row(fpt_pkg::CFG_WINDOW, 36'd0));
        // delta saturates
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd137438953473, 1'b0, RES_CLEAR));
        plan.push_back(cfg_row(fpt_pkg::CFG_TARGET, 36'd0));                 // default period
        plan.push_back(cfg_row(fpt_pkg::CFG_WINDOW, CFG_MAX));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd137472286807, 1'b0, RES_CLEAR));
        plan.push_back(beat_row(fpt_pkg::FUNC_SYNC, 63'd137472286812, 1'b0, RES_CLEAR));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle_idle();
                reg_write(plan[i].cfg_idx, plan[i].cfg_data);
            end else begin
                send_beat(plan[i].func, plan[i].now, plan[i].typed, plan[i].want);
            end
        end

        rand_beats = 0;
        while (rand_beats < 950) begin
            settle_idle();
            r64 = rand64();
            case ($urandom_range(0, 6))
                0: per = '0;
                1: per = 36'd1;
                2: per = 36'($urandom_range(2, 1000));
                3: per = fpt_pkg::DEFAULT_PERIOD_NS;
                4: per = r64[fpt_pkg::CFG_W-1:0];
                5: per = 36'($urandom_range(1000, 50000000));
                default: per = CFG_MAX;
            endcase
            period = (per != '0) ? {28'd0, per} : {28'd0, fpt_pkg::DEFAULT_PERIOD_NS};
            r64 = rand64();
            case ($urandom_range(0, 4))
                0: win = '0;
                1: win = 36'd1;
                2: begin
                    step = period * 64'($urandom_range(1, 8));
                    win  = step[fpt_pkg::CFG_W-1:0];
                end
                3: win = r64[fpt_pkg::CFG_W-1:0];
                default: win = CFG_MAX;
            endcase
            if ($urandom_range(0, 1) == 0) begin
                reg_write(fpt_pkg::CFG_TARGET, per);
                reg_write(fpt_pkg::CFG_WINDOW, win);
            end else begin
                reg_write(fpt_pkg::CFG_WINDOW, win);
                reg_write(fpt_pkg::CFG_TARGET, per);
            end
            quiet_phase = ($urandom_range(0, 4) == 0);

            r64 = rand64();
            case ($urandom_range(0, 3))
                0: stamp = '0;
                1: stamp = r64[fpt_pkg::NOW_W-1:0];
                2: stamp = STAMP_MAX - 63'($urandom_range(0, 1000000));
                default: stamp = {31'd0, r64[31:0]};
            endcase
            if ($urandom_range(0, 4) != 0) begin
                send_beat(fpt_pkg::FUNC_RESTART, stamp, 1'b0, RES_CLEAR);
                rand_beats++;
            end

            span = $urandom_range(20, 60);
            for (k = 0; k < span; k++) begin
                r64     = rand64();
                stamp64 = {1'b0, stamp};
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                        stamp64 = stamp64 + r64 % (period * 64'd2);
                    10, 11, 12:
                        stamp64 = stamp64 + period + r64 % (period / 64'd4 + 64'd1);
                    13, 14:             // long pause: delta falls back to one period
                        stamp64 = stamp64 + period * 64'd3 + 64'd1 + r64 % (period + 64'd1);
                    15:
                        stamp64 = stamp64;
                    16, 17:             // clock steps backwards
                        stamp64 = stamp64 - r64 % (period * 64'd2 + 64'd1);
                    default:
                        stamp64 = r64;
                endcase
                stamp = stamp64[fpt_pkg::NOW_W-1:0];
                func  = ($urandom_range(0, 24) == 0) ? fpt_pkg::FUNC_RESTART
                                                     : fpt_pkg::FUNC_SYNC;
                send_beat(func, stamp, 1'b0, RES_CLEAR);
                rand_beats++;
            end
        end

        settle_idle();
        repeat (100) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            $error("%0d expected results never arrived", outcome_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("PASS frame_pacing_timer_unit");
        else
            $display("FAIL frame_pacing_timer_unit");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAIL frame_pacing_timer_unit");
        $finish;
    end

endmodule
